FILE: hw/rtl/smt_pkg.sv
package smt_pkg;

  localparam int unsigned ValueW      = 32;
  localparam int unsigned EntryCountW = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic                     insert_en;
    logic                     remove_en;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

  // Compare outcome reported by one cell
  typedef struct packed {
    logic le;
    logic eq;
  } cell_flags_t;

endpackage

FILE: hw/rtl/smt_cell.sv
module smt_cell
  import smt_pkg::*;
(
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic                     valid,
  input  logic                     head,
  input  logic signed [ValueW-1:0] left_value,
  input  logic signed [ValueW-1:0] right_value,
  output logic signed [ValueW-1:0] entry,
  output cell_flags_t              flags
);

  logic signed [ValueW-1:0] entry_r;
  logic signed [ValueW-1:0] entry_nxt;
  logic                     ge;

  // Compare the held entry against the broadcast value
  always_comb begin
    flags.le = valid && (entry_r <= ctrl.value);
    flags.eq = valid && (entry_r == ctrl.value);
    ge       = valid && (entry_r >= ctrl.value);
  end

  // Keep, take the new value, or take a neighbour's entry
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.insert_en && !flags.le) begin
      entry_nxt = head ? ctrl.value : left_value;
    end else if (ctrl.remove_en && ge) begin
      entry_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

FILE: hw/rtl/sorted_multiset_table_top.sv
// Sorted multiset table: keeps up to TABLE_DEPTH signed 32-bit values in
// ascending order, duplicates allowed.
// Input channel: a command beat (in_command, in_value) is taken at a rising
// edge where start is high and busy is low. Insert places the value after
// every entry not larger than it, remove deletes one occurrence, query and
// the spare code only look the value up.
// Result channel: one beat per command, shown on out_status, out_found and
// out_entry_count for exactly one cycle while out_strobe is high, in the
// cycle after the command is taken. The receiver cannot hold results off.
// Throughput: one command per cycle while busy is low. Every cell of the row
// compares its entry with the command value in the same cycle and shifts left
// or right at the next edge, so each command is done before the next is taken.
// Reset (rst_n low, synchronous) empties the table and holds busy high for
// the first cycle after reset; entry contents are not cleared, the count
// alone marks which cells hold data.
module sorted_multiset_table_top
  import smt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_command,
  input  logic signed [ValueW-1:0] in_value,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic                     out_found,
  output logic [EntryCountW-1:0]   out_entry_count
);

  localparam int unsigned CountW = $clog2(TABLE_DEPTH + 1);

  logic                     busy_r;
  logic [CountW-1:0]        count_r;
  logic [CountW-1:0]        count_nxt;
  logic                     strobe_r;
  status_t                  status_r;
  status_t                  status_nxt;
  logic                     found_r;
  logic                     accept;
  logic                     full;
  logic                     present;
  cmd_t                     cmd;
  cell_ctrl_t               ctrl;
  logic signed [ValueW-1:0] entries [TABLE_DEPTH];
  cell_flags_t              flags   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   eq_vec;

  assign accept  = start && !busy_r;
  assign cmd     = cmd_t'(in_command);
  assign full    = (count_r == CountW'(TABLE_DEPTH));
  assign present = |eq_vec;

  // Decode the command and the new count
  always_comb begin
    ctrl.insert_en = 1'b0;
    ctrl.remove_en = 1'b0;
    ctrl.value     = in_value;
    status_nxt     = STAT_DONE;
    count_nxt      = count_r;
    unique case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          ctrl.insert_en = accept;
          count_nxt      = count_r + CountW'(1);
        end
      end
      CMD_REMOVE: begin
        if (!present) begin
          status_nxt = STAT_ABSENT;
        end else begin
          ctrl.remove_en = accept;
          count_nxt      = count_r - CountW'(1);
        end
      end
      CMD_QUERY, CMD_SPARE: begin
        status_nxt = STAT_DONE;
      end
      default: begin
        status_nxt = STAT_DONE;
      end
    endcase
  end

  // Row of cells; inner ones wired to both neighbours
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic                     head;
    logic signed [ValueW-1:0] left_value;
    logic signed [ValueW-1:0] right_value;

    if (g == 0) begin : g_first
      assign head       = 1'b1;
      assign left_value = in_value;
    end else begin : g_mid
      assign head       = flags[g-1].le;
      assign left_value = entries[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_last
      assign right_value = entries[g];
    end else begin : g_inner
      assign right_value = entries[g+1];
    end

    smt_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (CountW'(g) < count_r),
      .head        (head),
      .left_value  (left_value),
      .right_value (right_value),
      .entry       (entries[g]),
      .flags       (flags[g])
    );

    assign eq_vec[g] = flags[g].eq;
  end

  // Hold the count and the control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Capture the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      found_r  <= present;
    end
  end

  assign busy            = busy_r;
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_found       = found_r;
  assign out_entry_count = EntryCountW'(count_r);

endmodule

FILE: verif/tb_top.sv
module tb_top
  import smt_pkg::*;
();

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned RandPerPhase = 170;
  localparam int unsigned DirRows    = 22;

  localparam logic signed [ValueW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] ValMax = 32'sh7fff_ffff;

  typedef struct packed {
    status_t                status;
    logic                   found;
    logic [EntryCountW-1:0] count;
  } lookup_res_t;

  typedef struct {
    cmd_t                     cmd;
    logic signed [ValueW-1:0] value;
    bit                       typed;
    lookup_res_t              res;
  } dir_row_t;

  localparam lookup_res_t Unused = '{STAT_DONE, 1'b0, 7'd0};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_command = CMD_QUERY;
  logic signed [ValueW-1:0] in_value = '0;
  logic                     out_strobe;
  logic [1:0]               out_status;
  logic                     out_found;
  logic [EntryCountW-1:0]   out_entry_count;

  // Shadow copy of the sorted row and its fill level
  logic signed [ValueW-1:0] shadow_entries [TableDepth];
  int unsigned              shadow_count = 0;

  lookup_res_t pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned sender_idle_pct = 0;

  // Extremes, duplicates, absent removes and the spare code first
  dir_row_t dir_rows [DirRows] = '{
    '{CMD_QUERY,  32'sd0,          1'b1, '{STAT_DONE,   1'b0, 7'd0}},
    '{CMD_REMOVE, 32'sd5,          1'b1, '{STAT_ABSENT, 1'b0, 7'd0}},
    '{CMD_INSERT, ValMin,          1'b1, '{STAT_DONE,   1'b0, 7'd1}},
    '{CMD_INSERT, ValMax,          1'b1, '{STAT_DONE,   1'b0, 7'd2}},
    '{CMD_INSERT, 32'sd0,          1'b1, '{STAT_DONE,   1'b0, 7'd3}},
    '{CMD_INSERT, 32'sd0,          1'b1, '{STAT_DONE,   1'b1, 7'd4}},
    '{CMD_INSERT, -32'sd1,         1'b0, Unused},
    '{CMD_INSERT, 32'sd1,          1'b0, Unused},
    '{CMD_INSERT, 32'sh5555_5555,  1'b0, Unused},
    '{CMD_INSERT, 32'shaaaa_aaaa,  1'b0, Unused},
    '{CMD_QUERY,  ValMax,          1'b1, '{STAT_DONE,   1'b1, 7'd8}},
    '{CMD_QUERY,  ValMin,          1'b1, '{STAT_DONE,   1'b1, 7'd8}},
    '{CMD_SPARE,  32'sd0,          1'b1, '{STAT_DONE,   1'b1, 7'd8}},
    '{CMD_SPARE,  32'sd7,          1'b1, '{STAT_DONE,   1'b0, 7'd8}},
    '{CMD_REMOVE, 32'sd0,          1'b0, Unused},
    '{CMD_REMOVE, 32'sd0,          1'b0, Unused},
    '{CMD_REMOVE, 32'sd0,          1'b1, '{STAT_ABSENT, 1'b0, 7'd6}},
    '{CMD_REMOVE, ValMin,          1'b0, Unused},
    '{CMD_REMOVE, ValMax,          1'b0, Unused},
    '{CMD_QUERY,  -32'sd1,         1'b0, Unused},
    '{CMD_REMOVE, 32'shaaaa_aaaa,  1'b0, Unused},
    '{CMD_REMOVE, -32'sd2,         1'b1, '{STAT_ABSENT, 1'b0, 7'd3}}
  };

  sorted_multiset_table_top #(
    .TABLE_DEPTH(TableDepth)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_entry_count(out_entry_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one command to the shadow row and return what the block should report
  function automatic lookup_res_t apply_to_shadow(cmd_t cmd, logic signed [ValueW-1:0] val);
    lookup_res_t res;
    int          hit;
    int unsigned slot;
    hit  = -1;
    slot = 0;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (shadow_entries[i] == val && hit < 0) hit = i;
      if (shadow_entries[i] <= val) slot = i + 1;
    end
    res.status = STAT_DONE;
    res.found  = (hit >= 0);
    case (cmd)
      CMD_INSERT: begin
        if (shadow_count >= TableDepth) begin
          res.status = STAT_FULL;
        end else begin
          for (int unsigned i = shadow_count; i > slot; i--)
            shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[slot] = val;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (hit < 0) begin
          res.status = STAT_ABSENT;
        end else begin
          for (int unsigned i = hit; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    res.count = shadow_count[EntryCountW-1:0];
    return res;
  endfunction

  // Mix of extremes, a narrow band for duplicates and full-width noise
  function automatic logic signed [ValueW-1:0] pick_value();
    logic signed [ValueW-1:0] pool [8];
    int unsigned              r;
    pool = '{ValMin, ValMax, 32'sd0, -32'sd1, 32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sd42};
    r = $urandom_range(99);
    if (r < 30) return pool[$urandom_range(7)];
    if (r < 60) return $signed($urandom_range(15)) - 32'sd8;
    return $signed($urandom());
  endfunction

  // Prefer values already held so removes and queries mostly hit
  function automatic logic signed [ValueW-1:0] pick_lookup_value();
    if (shadow_count > 0 && $urandom_range(99) < 70)
      return shadow_entries[$urandom_range(shadow_count - 1)];
    return pick_value();
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $time, what);
  endtask

  // Present one command beat, hold it until taken, then record its expectation
  task automatic send_command(cmd_t cmd, logic signed [ValueW-1:0] val, bit typed,
                              lookup_res_t typed_res);
    lookup_res_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    do @(posedge clk); while (busy);
    predicted = apply_to_shadow(cmd, val);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    lookup_res_t exp_res;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: status %0d found %0d count %0d",
                                  out_status, out_found, out_entry_count));
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status || out_found !== exp_res.found ||
            out_entry_count !== exp_res.count)
          report_mismatch($sformatf(
            "expected status %0d found %0d count %0d, got status %0d found %0d count %0d",
            exp_res.status, exp_res.found, exp_res.count,
            out_status, out_found, out_entry_count));
      end
    end
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_strobe)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cmd_t        cmd;
    int unsigned r;
    bit          filling;
    int unsigned full_tries;
    int unsigned idle_pct [3];
    idle_pct   = '{20, 83, 0};
    filling    = 1'b1;
    full_tries = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    sender_idle_pct = 20;
    foreach (dir_rows[k])
      send_command(dir_rows[k].cmd, dir_rows[k].value, dir_rows[k].typed, dir_rows[k].res);

    // Random traffic: alternate filling to the top and draining to empty
    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = idle_pct[p];
      for (int unsigned k = 0; k < RandPerPhase; k++) begin
        r = $urandom_range(99);
        if (filling) begin
          if (r < 70)      cmd = CMD_INSERT;
          else if (r < 85) cmd = CMD_REMOVE;
          else if (r < 97) cmd = CMD_QUERY;
          else             cmd = CMD_SPARE;
        end else begin
          if (r < 20)      cmd = CMD_INSERT;
          else if (r < 85) cmd = CMD_REMOVE;
          else if (r < 97) cmd = CMD_QUERY;
          else             cmd = CMD_SPARE;
        end
        if (cmd == CMD_INSERT && shadow_count == TableDepth) full_tries++;
        if (cmd == CMD_INSERT)
          send_command(cmd, pick_value(), 1'b0, Unused);
        else
          send_command(cmd, pick_lookup_value(), 1'b0, Unused);
        if (filling && full_tries >= 3) begin
          filling    = 1'b0;
          full_tries = 0;
        end else if (!filling && shadow_count == 0) begin
          filling = 1'b1;
        end
      end
    end

    // Drain outstanding results, then allow for the pipeline latency
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
